// ===== src/rgb_linear_fade_defines.svh =====
// Assertion macros shared by the fade block modules.
`ifndef RGB_LINEAR_FADE_DEFINES_SVH
`define RGB_LINEAR_FADE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rlf_pkg.sv =====
// Package with constants and interface types of the fade block.
`timescale 1ns / 1ps
`default_nettype none
package rlf_pkg;

  localparam int CHANNELS_DEF     = 3;
  localparam int COLOUR_FIELDS    = 3;
  localparam int LEVEL_W          = 8;
  localparam int DELAY_W          = 16;
  localparam int IN_DATA_W        = 40;
  localparam int OUT_DATA_W       = 32;
  localparam logic [7:0] STEP_COUNT_RESET = 8'd50;
  localparam logic ACT_TARGET     = 1'b0;
  localparam logic ACT_TICK       = 1'b1;

  typedef struct packed {
    logic       go;
    logic [7:0] from;
    logic [7:0] to;
    logic [7:0] idx;
    logic [7:0] steps;
  } lerp_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] level;
  } lerp_rsp_t;

endpackage
`default_nettype wire

// ===== src/rlf_lerp.sv =====
// Shared interpolation unit: one multiply, then an eight-step restoring divide.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_linear_fade_defines.svh"
module rlf_lerp (
  input  wire              clk,
  input  wire              rst,
  input  rlf_pkg::lerp_req_t req,
  output rlf_pkg::lerp_rsp_t rsp
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_FIX  = 4'b1000
  } ustate_t;

  ustate_t    state;
  logic [7:0] from;
  logic [7:0] mag;
  logic [7:0] idx;
  logic [7:0] steps;
  logic       neg;
  logic [7:0] rem;
  logic [7:0] dq;
  logic [2:0] cnt;
  logic [15:0] prod;
  logic [8:0] trial;
  logic       trial_ge;
  logic [8:0] trial_sub;
  logic [8:0] lo_sum;
  logic [8:0] lo_dif;

  assign prod      = 16'(mag) * 16'(idx);
  assign trial     = {rem, dq[7]};
  assign trial_ge  = (trial >= {1'b0, steps});
  assign trial_sub = trial - {1'b0, steps};
  assign lo_sum    = {1'b0, from} + {1'b0, dq};
  assign lo_dif    = {1'b0, from} - {1'b0, dq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == U_FIX);
      case (state)
        U_IDLE: begin
          if (req.go) begin
            from  <= req.from;
            neg   <= (req.to < req.from);
            mag   <= (req.to < req.from) ? (req.from - req.to) : (req.to - req.from);
            idx   <= req.idx;
            steps <= req.steps;
            state <= U_MUL;
          end
        end
        U_MUL: begin
          rem   <= prod[15:8];
          dq    <= prod[7:0];
          cnt   <= 3'd0;
          state <= U_DIV;
        end
        U_DIV: begin
          rem   <= trial_ge ? trial_sub[7:0] : trial[7:0];
          dq    <= {dq[6:0], trial_ge};
          cnt   <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          if (neg) begin
            rsp.level <= lo_dif[8] ? 8'd0 : lo_dif[7:0];
          end else begin
            rsp.level <= lo_sum[8] ? 8'hFF : lo_sum[7:0];
          end
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  `RLF_ASSERT_NOW(a_go_idle, req.go, state == U_IDLE, "lerp start while busy")
  `RLF_ASSERT_NOW(a_rem_bound, state == U_DIV, rem < steps, "remainder out of range")
  `RLF_ASSERT_NEXT(a_done_pulse, rsp.done, !rsp.done, "done longer than one cycle")

endmodule
`default_nettype wire

// ===== src/rgb_linear_fade.sv =====
// Top level of the linear LED colour fade block.
//
// channel | direction | handshake           | payload
// s_      | in        | s_tvalid / s_tready | s_tuser action, s_tdata target and delay
// m_      | out       | m_tvalid / m_tready | m_tdata drive levels and fading flag
// cfg_    | in        | cfg_we              | cfg_data step count
//
// A target item or a tick that does not land on an interior step goes straight to ST_DONE.
// A tick that lands on an interior step launches the shared interpolation unit
// (multiply, 8 divide steps, fix-up) once per channel, then goes to ST_DONE.
// Synchronous reset sets the control state, counters and colours, not m_tdata; step count resets to 50.
// A result waits in the output register; one further item may be taken meanwhile,
// and its result is held until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_linear_fade_defines.svh"
module rgb_linear_fade #(
  parameter int CHANNELS = rlf_pkg::CHANNELS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // target_red, target_green, target_blue, step_delay
  input  wire  [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // drive_red, drive_green, drive_blue, fading, zero pad
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_data   // step_count
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t      state;
  logic [7:0]  start_c  [CHANNELS];
  logic [7:0]  target_c [CHANNELS];
  logic [7:0]  shown_c  [CHANNELS];
  logic [7:0]  step_index;
  logic [15:0] tick_count;
  logic [15:0] delay_held;
  logic        busy;
  logic [7:0]  step_count;
  logic [7:0]  steps_held;
  logic [CH_W-1:0] ch;

  logic        s_fire;
  logic [15:0] tick_next;
  logic [7:0]  idx_next;
  logic [7:0]  steps_eff;
  logic [15:0] in_delay;
  logic [23:0] drive;

  rlf_pkg::lerp_req_t req;
  rlf_pkg::lerp_rsp_t rsp;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign tick_next = tick_count + 16'd1;
  assign idx_next  = (step_index < 8'hFF) ? (step_index + 8'd1) : step_index;
  assign steps_eff = (step_count == 8'd0) ? 8'd1 : step_count;
  assign in_delay  = s_tdata[39:24];

  always_comb begin
    req.go    = (state == ST_LAUNCH);
    req.from  = start_c[ch];
    req.to    = target_c[ch];
    req.idx   = step_index;
    req.steps = steps_held;
  end

  always_comb begin
    drive = '0;
    for (int c = 0; c < rlf_pkg::COLOUR_FIELDS; c++) begin
      if (c < CHANNELS) begin
        drive[c*8 +: 8] = shown_c[c];
      end
    end
  end

  rlf_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= rlf_pkg::STEP_COUNT_RESET;
    end else if (cfg_we) begin
      step_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step_index <= '0;
      tick_count <= '0;
      delay_held <= '0;
      busy       <= 1'b0;
      steps_held <= 8'd1;
      ch         <= '0;
      m_tvalid   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        start_c[c]  <= '0;
        target_c[c] <= '0;
        shown_c[c]  <= '0;
      end
    end else begin
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_DONE;
            if (s_tuser[0] == rlf_pkg::ACT_TARGET) begin
              for (int c = 0; c < CHANNELS; c++) begin
                start_c[c]  <= shown_c[c];
                target_c[c] <= (c < rlf_pkg::COLOUR_FIELDS) ? s_tdata[(c % 3)*8 +: 8] : 8'd0;
              end
              step_index <= '0;
              tick_count <= '0;
              delay_held <= (in_delay == 16'd0) ? 16'd1 : in_delay;
              busy       <= 1'b1;
            end else if (busy) begin
              if (tick_next >= delay_held) begin
                tick_count <= '0;
                step_index <= idx_next;
                steps_held <= steps_eff;
                if (idx_next >= steps_eff) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                    shown_c[c] <= target_c[c];
                  end
                  busy <= 1'b0;
                end else begin
                  ch    <= '0;
                  state <= ST_LAUNCH;
                end
              end else begin
                tick_count <= tick_next;
              end
            end
          end
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            shown_c[ch] <= rsp.level;
            if (ch == CH_W'(CHANNELS - 1)) begin
              state <= ST_DONE;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_LAUNCH;
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {7'd0, busy, drive};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RLF_ASSERT_NEXT(a_one_item, s_fire, !s_tready, "item taken while another is at work")
  `RLF_ASSERT_NOW(a_done_waited, rsp.done, state == ST_WAIT, "lerp result with no one waiting")
  `RLF_ASSERT_NOW(a_interior, state == ST_LAUNCH, step_index < steps_held,
                  "interpolation launched on the final step")

endmodule
`default_nettype wire
